// File: src/fvn_pkg.sv
// Package for the fractal value noise block: shared widths, hash constants,
// register indexes and the lane control type. No dependencies.
package fvn_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned FreqW   = 32;
  localparam int unsigned SeedW   = 64;
  localparam int unsigned AmpW    = 17;
  localparam int unsigned ValW    = 16;
  localparam int unsigned WeightW = ValW + AmpW;

  // Register stages inside one octave lane.
  localparam int unsigned LaneStg = 9;

  // Divider: 16 quotient bits, two per stage.
  localparam int unsigned QuoW   = 16;
  localparam int unsigned DivBps = 2;
  localparam int unsigned DivStg = QuoW / DivBps;

  localparam logic [AmpW-1:0] AmpOne = AmpW'(65536);

  localparam logic [31:0] HashXMul  = 32'd73856093;
  localparam logic [31:0] HashYMul  = 32'd19349663;
  localparam logic [63:0] FmixMulA  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FmixMulB  = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned FmixShift = 33;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_SEED      = 3'd0,
    REG_OCTAVE_COUNT   = 3'd1,
    REG_PERSISTENCE    = 3'd2,
    REG_LACUNARITY     = 3'd3,
    REG_BASE_FREQUENCY = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [LaneStg-1:0] adv;
  } lane_ctl_t;

  function automatic logic [63:0] xor_shift(input logic [63:0] h);
    return h ^ (h >> FmixShift);
  endfunction

endpackage

// File: src/fvn_octave.sv
// One octave lane of the fractal value noise pipeline: scaling, corner hash,
// quintic fade, bilinear blend and amplitude weighting. Depends on fvn_pkg.
module fvn_octave import fvn_pkg::*; (
  input  logic               clk_i,
  input  lane_ctl_t          ctl_i,
  input  logic [CoordW-1:0]  x_coord_i,
  input  logic [CoordW-1:0]  y_coord_i,
  input  logic [FreqW-1:0]   freq_i,
  input  logic [SeedW-1:0]   seed_i,
  input  logic [AmpW-1:0]    amp_i,
  output logic [WeightW-1:0] weighted_o
);

  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] f);
    logic [32:0] s;
    s = {17'b0, a} * (33'd65536 - {17'b0, f}) + {17'b0, b} * {17'b0, f};
    return s[31:16];
  endfunction

  // Stage 0: scaled positions.
  logic [47:0] px_q, py_q;
  // Stage 1: row/column hash products and fade squares.
  logic [31:0] hx0_q, hx1_q, hy0_q, hy1_q;
  logic [15:0] tx_q, ty_q;
  logic [31:0] ttx_q, tty_q;
  // Stage 2: first mixer partial products, fade cube and polynomial.
  logic [63:0] ll1_q [4];
  logic [31:0] lh1_q [4];
  logic [31:0] hl1_q [4];
  logic [15:0] cx_q, cy_q;
  logic [20:0] qx_q, qy_q;
  // Stage 3: first mixer product, fade weights.
  logic [63:0] m1_q [4];
  logic [15:0] fx_q, fy_q;
  // Stage 4: second mixer partial products.
  logic [63:0] ll2_q [4];
  logic [31:0] lh2_q [4];
  logic [31:0] hl2_q [4];
  logic [15:0] fx4_q, fy4_q;
  // Stage 5: corner values.
  logic [15:0] corner_q [4];
  logic [15:0] fx5_q, fy5_q;
  // Stage 6: horizontal blends.
  logic [15:0] ba_q, bb_q, fy6_q;
  // Stage 7: vertical blend.
  logic [15:0] val_q;
  // Stage 8: weighted value.
  logic [WeightW-1:0] weighted_q;

  logic [31:0] hx0_d, hx1_d, hy0_d, hy1_d;
  logic [63:0] k1 [4];
  logic [63:0] k2 [4];
  logic [47:0] cubx, cuby;
  logic [36:0] polx, poly;
  logic [36:0] cqx, cqy;
  logic [63:0] m2 [4];

  always_comb begin
    hx0_d = {8'b0, px_q[47:24]} * HashXMul;
    hx1_d = ({8'b0, px_q[47:24]} + 32'd1) * HashXMul;
    hy0_d = {8'b0, py_q[47:24]} * HashYMul;
    hy1_d = ({8'b0, py_q[47:24]} + 32'd1) * HashYMul;
  end

  // Corner order: (x0,y0), (x1,y0), (x0,y1), (x1,y1).
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [31:0] hx, hy;
      hx = c[0] ? hx1_q : hx0_q;
      hy = c[1] ? hy1_q : hy0_q;
      k1[c] = xor_shift({{32{hx[31]}}, hx} ^ {{32{hy[31]}}, hy} ^ seed_i);
      k2[c] = xor_shift(m1_q[c]);
      m2[c] = ll2_q[c] + {lh2_q[c] + hl2_q[c], 32'b0};
    end
  end

  always_comb begin
    cubx = {16'b0, ttx_q} * {32'b0, tx_q};
    cuby = {16'b0, tty_q} * {32'b0, ty_q};
    polx = 37'd6 * {5'b0, ttx_q} + (37'd10 << 32) - (({21'b0, tx_q}) << 16) * 37'd15;
    poly = 37'd6 * {5'b0, tty_q} + (37'd10 << 32) - (({21'b0, ty_q}) << 16) * 37'd15;
    cqx  = {21'b0, cx_q} * {16'b0, qx_q};
    cqy  = {21'b0, cy_q} * {16'b0, qy_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv[0]) begin
      px_q <= {32'b0, x_coord_i} * {16'b0, freq_i};
      py_q <= {32'b0, y_coord_i} * {16'b0, freq_i};
    end
    if (ctl_i.adv[1]) begin
      hx0_q <= hx0_d;
      hx1_q <= hx1_d;
      hy0_q <= hy0_d;
      hy1_q <= hy1_d;
      tx_q  <= px_q[23:8];
      ty_q  <= py_q[23:8];
      ttx_q <= {16'b0, px_q[23:8]} * {16'b0, px_q[23:8]};
      tty_q <= {16'b0, py_q[23:8]} * {16'b0, py_q[23:8]};
    end
    if (ctl_i.adv[2]) begin
      for (int c = 0; c < 4; c++) begin
        ll1_q[c] <= {32'b0, k1[c][31:0]} * {32'b0, FmixMulA[31:0]};
        lh1_q[c] <= k1[c][31:0] * FmixMulA[63:32];
        hl1_q[c] <= k1[c][63:32] * FmixMulA[31:0];
      end
      cx_q <= cubx[47:32];
      cy_q <= cuby[47:32];
      qx_q <= polx[36:16];
      qy_q <= poly[36:16];
    end
    if (ctl_i.adv[3]) begin
      for (int c = 0; c < 4; c++) begin
        m1_q[c] <= ll1_q[c] + {lh1_q[c] + hl1_q[c], 32'b0};
      end
      fx_q <= (|cqx[36:32]) ? 16'hFFFF : cqx[31:16];
      fy_q <= (|cqy[36:32]) ? 16'hFFFF : cqy[31:16];
    end
    if (ctl_i.adv[4]) begin
      for (int c = 0; c < 4; c++) begin
        ll2_q[c] <= {32'b0, k2[c][31:0]} * {32'b0, FmixMulB[31:0]};
        lh2_q[c] <= k2[c][31:0] * FmixMulB[63:32];
        hl2_q[c] <= k2[c][63:32] * FmixMulB[31:0];
      end
      fx4_q <= fx_q;
      fy4_q <= fy_q;
    end
    if (ctl_i.adv[5]) begin
      // The final xor-shift leaves the top 16 bits untouched.
      for (int c = 0; c < 4; c++) begin
        corner_q[c] <= m2[c][63:48];
      end
      fx5_q <= fx4_q;
      fy5_q <= fy4_q;
    end
    if (ctl_i.adv[6]) begin
      ba_q  <= blend(corner_q[0], corner_q[1], fx5_q);
      bb_q  <= blend(corner_q[2], corner_q[3], fx5_q);
      fy6_q <= fy5_q;
    end
    if (ctl_i.adv[7]) begin
      val_q <= blend(ba_q, bb_q, fy6_q);
    end
    if (ctl_i.adv[8]) begin
      weighted_q <= {17'b0, val_q} * {16'b0, amp_i};
    end
  end

  assign weighted_o = weighted_q;

endmodule

// File: src/fractal_value_noise_2d.sv
// Top level of the fractal value noise block: configuration registers, octave
// table sequencer, octave lanes, sum and pipelined divider. Depends on fvn_pkg, fvn_octave.
//
// This block returns one Q0.16 fractal value noise sample for each coordinate
// transaction and accepts a new transaction in every cycle once running, unless
// an output stall has filled every stage. Each transaction passes through 9 lane
// stages (all octaves in parallel lanes), one summing stage and 8 divider stages.
// Stalls on the output fill empty stages first, so the input keeps accepting
// while bubbles remain. After reset and after every configuration write, a
// sequencer builds the per-octave frequency, amplitude and seed table in a start
// step and then one step per octave; input ready stays low during that time.
// Configuration writes are always ready.
module fractal_value_noise_2d import fvn_pkg::*; #(
  parameter int unsigned MAX_OCTAVES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CoordW-1:0]  x_coord_i,
  input  logic [CoordW-1:0]  y_coord_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [QuoW-1:0]    noise_value_o
);

  localparam int unsigned IdxW   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int unsigned CntW   = $clog2(MAX_OCTAVES + 1);
  localparam int unsigned TotW   = AmpW + CntW;
  localparam int unsigned SumW   = WeightW + CntW;
  localparam int unsigned NumStg = LaneStg + 1 + DivStg;

  // Configuration registers.
  logic [63:0] base_seed_q;
  logic [3:0]  octave_count_q;
  logic [15:0] persistence_q;
  logic [15:0] lacunarity_q;
  logic [31:0] base_frequency_q;

  logic cfg_fire;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_seed_q      <= 64'd0;
      octave_count_q   <= 4'd4;
      persistence_q    <= 16'd32768;
      lacunarity_q     <= 16'd512;
      base_frequency_q <= 32'd167772;
    end else if (cfg_fire) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_BASE_SEED:      base_seed_q      <= cfg_data_i;
        REG_OCTAVE_COUNT:   octave_count_q   <= cfg_data_i[3:0];
        REG_PERSISTENCE:    persistence_q    <= cfg_data_i[15:0];
        REG_LACUNARITY:     lacunarity_q     <= cfg_data_i[15:0];
        REG_BASE_FREQUENCY: base_frequency_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Octave table sequencer. It walks the octaves one per cycle, stepping the
  // frequency (saturating) and amplitude exactly as the octave loop would,
  // and records a zero weight for octaves beyond the configured count.
  logic              start_q, run_q;
  logic [IdxW-1:0]   idx_q;
  logic [FreqW-1:0]  freq_acc_q;
  logic [AmpW-1:0]   amp_acc_q;
  logic [SeedW-1:0]  seed_acc_q;
  logic [TotW-1:0]   total_q;

  logic [FreqW-1:0]  freq_tab_q [MAX_OCTAVES];
  logic [AmpW-1:0]   amp_tab_q  [MAX_OCTAVES];
  logic [SeedW-1:0]  seed_tab_q [MAX_OCTAVES];

  logic              seq_step, seq_last, busy;
  logic [47:0]       freq_prod;
  logic [32:0]       amp_prod;
  logic [FreqW-1:0]  freq_next;
  logic [AmpW-1:0]   amp_eff;

  always_comb begin
    freq_prod = {16'b0, freq_acc_q} * {32'b0, lacunarity_q};
    freq_next = (|freq_prod[47:40]) ? '1 : freq_prod[39:8];
    amp_prod  = {16'b0, amp_acc_q} * {17'b0, persistence_q};
    amp_eff   = (5'(idx_q) < 5'(octave_count_q)) ? amp_acc_q : '0;
    seq_last  = (idx_q == IdxW'(MAX_OCTAVES - 1));
    seq_step  = run_q && !start_q && !cfg_fire;
    busy      = start_q || run_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= 1'b1;
      run_q      <= 1'b0;
      idx_q      <= '0;
      freq_acc_q <= '0;
      amp_acc_q  <= '0;
      seed_acc_q <= '0;
      total_q    <= '0;
    end else if (cfg_fire) begin
      start_q <= 1'b1;
      run_q   <= 1'b0;
    end else if (start_q) begin
      start_q    <= 1'b0;
      run_q      <= 1'b1;
      idx_q      <= '0;
      freq_acc_q <= base_frequency_q;
      amp_acc_q  <= AmpOne;
      seed_acc_q <= base_seed_q;
      total_q    <= '0;
    end else if (run_q) begin
      idx_q      <= idx_q + IdxW'(1);
      freq_acc_q <= freq_next;
      amp_acc_q  <= amp_prod[32:16];
      seed_acc_q <= seed_acc_q + 64'd1;
      total_q    <= total_q + TotW'(amp_eff);
      if (seq_last) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_step) begin
      freq_tab_q[idx_q] <= freq_acc_q;
      amp_tab_q[idx_q]  <= amp_eff;
      seed_tab_q[idx_q] <= seed_acc_q;
    end
  end

  // Stage handshake: a stage loads when it is empty or its successor loads,
  // so bubbles collapse and a stall neither drops nor repeats a transaction.
  logic [NumStg:0]   adv;
  logic [NumStg-1:0] v_q;
  logic              in_fire;

  always_comb begin
    adv[NumStg] = out_ready_i;
    for (int k = NumStg - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0] && !busy;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_fire;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Octave lanes.
  lane_ctl_t          lane_ctl;
  logic [WeightW-1:0] weighted [MAX_OCTAVES];

  assign lane_ctl.adv = adv[LaneStg-1:0];

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
    fvn_octave u_octave (
      .clk_i      (clk_i),
      .ctl_i      (lane_ctl),
      .x_coord_i  (x_coord_i),
      .y_coord_i  (y_coord_i),
      .freq_i     (freq_tab_q[i]),
      .seed_i     (seed_tab_q[i]),
      .amp_i      (amp_tab_q[i]),
      .weighted_o (weighted[i])
    );
  end

  // Sum of the amplitude-weighted octave values.
  logic [SumW-1:0] sum_d, sum_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      sum_d = sum_d + SumW'(weighted[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[LaneStg]) begin
      sum_q <= sum_d;
    end
  end

  // Restoring divider by the amplitude total, two quotient bits per stage.
  // The sum is always below total * 2^16, so sixteen bits hold the quotient.
  // A zero total (no octaves) gives zero.
  logic [SumW-1:0] rem_q [DivStg];
  logic [QuoW-1:0] quo_q [DivStg];

  for (genvar s = 0; s < DivStg; s++) begin : g_div
    logic [SumW-1:0] rem_in, rem_d;
    logic [QuoW-1:0] quo_in, quo_d;

    if (s == 0) begin : g_first
      assign rem_in = sum_q;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      logic [SumW-1:0] dsh;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < DivBps; j++) begin
        dsh = SumW'(total_q) << (QuoW - 1 - DivBps * s - j);
        if (rem_d >= dsh) begin
          rem_d = rem_d - dsh;
          quo_d[QuoW - 1 - DivBps * s - j] = 1'b1;
        end
      end
      if (s == DivStg - 1 && total_q == '0) begin
        quo_d = '0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[LaneStg + 1 + s]) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign out_valid_o   = v_q[NumStg-1];
  assign noise_value_o = quo_q[DivStg-1];

endmodule
